/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/itp_pkg.sv */
// Shared types, constants and functions of the infix to postfix converter.
package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CHAR_W      = 8;
   localparam int ERR_W       = 2;
   localparam int PREC_W      = 3;

   localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(STACK_DEPTH);

   localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h28;
   localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h29;
   localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_TERM   = 8'h00;

   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_OPER,
      ST_LOAD,
      ST_TAIL,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   // Precedence ranked upward from zero: parentheses lowest.
   function automatic logic [PREC_W-1:0] prec_of(input logic [CHAR_W-1:0] c);
      logic [PREC_W-1:0] p;
      case (c) inside
         CH_CARET:           p = 3'd4;
         CH_STAR, CH_SLASH:  p = 3'd3;
         CH_PLUS, CH_MINUS:  p = 3'd2;
         CH_OPEN, CH_CLOSE:  p = 3'd0;
         default:            p = 3'd1;
      endcase
      return p;
   endfunction

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
   endfunction

endpackage

/* hw/rtl/itp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/infix_to_postfix_converter_core.sv */
// Shunting-yard infix to postfix converter, top level.
// Takes one infix character per req_ beat and returns its postfix characters as rsp_ beats;
// letters pass at once, operators wait on a 32-entry stack in RAM, and the beat marked last
// flushes the stack and ends with a zero terminator. The block takes one character at a time
// and is ready for the next only in idle; each pop, and the drop of the matching '(', passes
// through a load state, because the stack top is cached in a register and each pop re-reads
// the new top through the RAM's registered read port. For the last character the block also
// flushes every entry and emits the terminator. A low rsp_ready stalls the emitting states.
// rsp_end_of_run marks the last beat caused by a character, and rsp_error_code carries the
// sticky error (1 unmatched close parenthesis, 2 stack overflow) as it stands after that
// character; only reset clears it.
`include "assert_macros.svh"

module infix_to_postfix_converter_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [itp_pkg::CHAR_W-1:0]   req_char_in,
   input  logic                         req_is_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [itp_pkg::CHAR_W-1:0]   rsp_char_out,
   output logic                         rsp_end_of_run,
   output logic [itp_pkg::ERR_W-1:0]    rsp_error_code
);

   import itp_pkg::*;

   state_type          state_ff, state_in;
   state_type          ret_ff, ret_in;
   logic [CHAR_W-1:0]  c_ff, c_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   paren_ff, paren_in;
   logic [CHAR_W-1:0]  top_ff, top_in;
   logic [ERR_W-1:0]   sticky_ff, sticky_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0]  pend_char_ff, pend_char_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_end_ff, out_end_in;
   logic [ERR_W-1:0]   out_err_ff, out_err_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [CHAR_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [CHAR_W-1:0]  ram_rdata;

   logic               req_accept;
   logic               out_free;
   logic               can_emit;
   logic               pops_op;
   logic               emit_req;
   logic [CHAR_W-1:0]  emit_char;
   logic               emit_fire;
   logic               fin_fire;
   logic               err_open;
   logic               err_close;
   logic               err_oper;

   itp_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !out_valid_ff || rsp_ready;
   assign can_emit   = !pend_valid_ff || out_free;
   assign pops_op    = (cnt_ff != '0) && !(prec_of(c_ff) > prec_of(top_ff));

   // Read the entry below the top; it becomes the top after a pop.
   assign ram_raddr  = ADDR_W'(cnt_ff - CNT_W'(2));

   // Errors are settled at accept so every beat of the character carries the final code.
   assign err_open  = (req_char_in == CH_OPEN) && (cnt_ff == STACK_FULL);
   assign err_close = (req_char_in == CH_CLOSE) && (paren_ff == '0);
   assign err_oper  = !is_letter(req_char_in) && (req_char_in != CH_OPEN)
                      && (req_char_in != CH_CLOSE) && (cnt_ff == STACK_FULL)
                      && (prec_of(req_char_in) > prec_of(top_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (is_letter(req_char_in) || (req_char_in == CH_OPEN)) begin
                  state_in = ST_TAIL;
               end else if (req_char_in == CH_CLOSE) begin
                  state_in = ST_CLOSE;
               end else begin
                  state_in = ST_OPER;
               end
            end
         end
         ST_CLOSE: begin
            if (cnt_ff == '0) begin
               state_in = ST_TAIL;
            end else if (top_ff == CH_OPEN) begin
               state_in = ST_LOAD;
               ret_in   = ST_TAIL;
            end else if (can_emit) begin
               state_in = ST_LOAD;
               ret_in   = ST_CLOSE;
            end
         end
         ST_OPER: begin
            if (pops_op) begin
               if (can_emit) begin
                  state_in = ST_LOAD;
                  ret_in   = ST_OPER;
               end
            end else begin
               state_in = ST_TAIL;
            end
         end
         ST_LOAD: state_in = ret_ff;
         ST_TAIL: state_in = last_ff ? ST_FLUSH : ST_FINISH;
         ST_FLUSH: begin
            if (can_emit) begin
               if (cnt_ff != '0) begin
                  state_in = ST_LOAD;
                  ret_in   = ST_FLUSH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Stack and sequencer datapath
   always_comb begin
      c_in      = c_ff;
      last_in   = last_ff;
      cnt_in    = cnt_ff;
      paren_in  = paren_ff;
      top_in    = top_ff;
      sticky_in = sticky_ff;
      ram_we    = 1'b0;
      ram_waddr = cnt_ff[ADDR_W-1:0];
      ram_wdata = req_char_in;
      emit_req  = 1'b0;
      emit_char = top_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               c_in    = req_char_in;
               last_in = req_is_last;
               if (sticky_ff == ERR_NONE) begin
                  if (err_close) begin
                     sticky_in = ERR_UNMATCHED;
                  end else if (err_open || err_oper) begin
                     sticky_in = ERR_OVERFLOW;
                  end
               end
               if (is_letter(req_char_in)) begin
                  emit_req  = 1'b1;
                  emit_char = req_char_in;
               end else if ((req_char_in == CH_OPEN) && (cnt_ff != STACK_FULL)) begin
                  ram_we   = 1'b1;
                  top_in   = req_char_in;
                  cnt_in   = cnt_ff + CNT_W'(1);
                  paren_in = paren_ff + CNT_W'(1);
               end
            end
         end
         ST_CLOSE: begin
            if (cnt_ff != '0) begin
               if (top_ff == CH_OPEN) begin
                  cnt_in   = cnt_ff - CNT_W'(1);
                  paren_in = paren_ff - CNT_W'(1);
               end else begin
                  emit_req = 1'b1;
                  if (can_emit) begin
                     cnt_in = cnt_ff - CNT_W'(1);
                  end
               end
            end
         end
         ST_OPER: begin
            if (pops_op) begin
               emit_req = 1'b1;
               if (can_emit) begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end else if (cnt_ff != STACK_FULL) begin
               ram_we    = 1'b1;
               ram_wdata = c_ff;
               top_in    = c_ff;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
         end
         ST_LOAD: top_in = ram_rdata;
         ST_TAIL: begin
         end
         ST_FLUSH: begin
            emit_req = 1'b1;
            if (cnt_ff != '0) begin
               if (can_emit) begin
                  cnt_in = cnt_ff - CNT_W'(1);
                  if (top_ff == CH_OPEN) begin
                     paren_in = paren_ff - CNT_W'(1);
                  end
               end
            end else begin
               emit_char = CH_TERM;
            end
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Hold one result back until the next one, or the end of the character, shows whether it is
   // the last beat.
   assign emit_fire = emit_req && can_emit;
   assign fin_fire  = (state_ff == ST_FINISH) && pend_valid_ff && out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      out_valid_in  = out_valid_ff;
      out_char_in   = out_char_ff;
      out_end_in    = out_end_ff;
      out_err_in    = out_err_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (emit_fire) begin
         pend_valid_in = 1'b1;
         pend_char_in  = emit_char;
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_char_in  = pend_char_ff;
            out_end_in   = 1'b0;
            out_err_in   = sticky_ff;
         end
      end else if (fin_fire) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
         out_char_in   = pend_char_ff;
         out_end_in    = 1'b1;
         out_err_in    = sticky_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         cnt_ff        <= '0;
         paren_ff      <= '0;
         sticky_ff     <= ERR_NONE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         cnt_ff        <= cnt_in;
         paren_ff      <= paren_in;
         sticky_ff     <= sticky_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff         <= c_in;
      last_ff      <= last_in;
      top_ff       <= top_in;
      pend_char_ff <= pend_char_in;
      out_char_ff  <= out_char_in;
      out_end_ff   <= out_end_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_char_out   = out_char_ff;
   assign rsp_end_of_run = out_end_ff;
   assign rsp_error_code = out_err_ff;

   `ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= STACK_FULL, "stack count beyond depth")
   `ASSERT_ALWAYS(a_paren_bound, paren_ff <= cnt_ff, "open parenthesis count above stack count")
   `ASSERT_ALWAYS(a_idle_no_pend, (state_ff != ST_IDLE) || !pend_valid_ff, "result held in idle")
   `ASSERT_NEXT(a_sticky_hold, sticky_ff != ERR_NONE, $stable(sticky_ff), "sticky error changed")

endmodule
